// ===== rtl/core/mpe_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time core.
package mpe_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int ITER_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd6;

    // Configuration register file contents
    typedef struct packed {
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [ITER_W-1:0]  max_iterations;
    } cfg_t;

    // One mapped pixel handed from front to back
    typedef struct packed {
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } job_t;

endpackage

// ===== rtl/core/mpe_div.sv =====
// Restoring divider: one quotient bit per cycle, unsigned magnitude by 11-bit divisor.
module mpe_div #(
    parameter int NUM_W = 45
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [NUM_W-1:0]         num_mag,
    input  logic [mpe_pkg::DIM_W-1:0] divisor,
    output logic                     done,
    output logic [NUM_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam int D_W   = mpe_pkg::DIM_W;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [D_W:0]     rem_shift;
    logic [D_W:0]     rem_diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    // Load on start, else advance one bit while busy
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num_mag;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_diff[D_W-1:0] : rem_shift[D_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/mpe_front.sv =====
// Front end: accepts a pixel, derives the window steps and maps it to a point c.
module mpe_front #(
    parameter int STEP_SCALE_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mpe_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [mpe_pkg::POS_W-1:0] in_col,
    input  logic [mpe_pkg::POS_W-1:0] in_row,
    output logic                      job_valid,
    input  logic                      job_ready,
    output mpe_pkg::job_t             job
);

    localparam int CW    = mpe_pkg::COORD_W;
    localparam int PW    = mpe_pkg::POS_W;
    localparam int NUM_W = CW + 1 + STEP_SCALE_BITS;
    localparam int Q_W   = NUM_W + 1;
    localparam int PX_W  = CW + PW;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIVX = 5'b00010,
        F_DIVY = 5'b00100,
        F_MUL  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [PW-1:0] col_reg, row_reg;
    logic [CW-1:0] stepx_reg, stepy_reg;
    logic [CW-1:0] prodx_reg, prody_reg;
    logic          neg_reg, zero_reg;

    logic                          sel_y;
    logic [CW-1:0]                 corner_a, corner_b;
    logic [mpe_pkg::DIM_W-1:0]     divisor;
    logic [CW:0]                   diff;
    logic [CW:0]                   mag;
    logic [NUM_W-1:0]              num_mag;
    logic                          div_start;
    logic                          div_done;
    logic [NUM_W-1:0]              div_quo;
    logic [Q_W-1:0]                q_ext, q_signed;
    logic [CW-1:0]                 step_val;
    logic [PX_W-1:0]               px_full, py_full;
    logic                          accept;

    // Pick the axis for the divide being started
    assign sel_y    = (state_reg == F_DIVX);
    assign corner_a = sel_y ? cfg.top_y : cfg.left_x;
    assign corner_b = sel_y ? cfg.bottom_y : cfg.right_x;
    assign divisor  = sel_y ? cfg.image_height : cfg.image_width;

    // Span as a sign and a scaled magnitude
    assign diff    = {corner_b[CW-1], corner_b} - {corner_a[CW-1], corner_a};
    assign mag     = diff[CW] ? (~diff + 1'b1) : diff;
    assign num_mag = NUM_W'(mag) << STEP_SCALE_BITS;

    assign accept    = in_valid && (state_reg == F_IDLE);
    assign div_start = accept || ((state_reg == F_DIVX) && div_done);

    mpe_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num_mag  (num_mag),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Restore the sign, truncating toward zero, then drop the scale bits
    assign q_ext    = {1'b0, div_quo};
    assign q_signed = neg_reg ? (~q_ext + 1'b1) : q_ext;
    assign step_val = zero_reg ? '0 : q_signed[STEP_SCALE_BITS+CW-1:STEP_SCALE_BITS];

    // Step times index, low word only
    assign px_full = stepx_reg * col_reg;
    assign py_full = stepy_reg * row_reg;

    // Sequence one pixel through both divides, the scaling and the push
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) state_next = F_DIVX;
            end
            F_DIVX: begin
                if (div_done) state_next = F_DIVY;
            end
            F_DIVY: begin
                if (div_done) state_next = F_MUL;
            end
            F_MUL: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (job_ready) state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (accept) begin
            col_reg <= in_col;
            row_reg <= in_row;
        end
        if (div_start) begin
            neg_reg  <= diff[CW];
            zero_reg <= (divisor == '0);
        end
        if ((state_reg == F_DIVX) && div_done) stepx_reg <= step_val;
        if ((state_reg == F_DIVY) && div_done) stepy_reg <= step_val;
        if (state_reg == F_MUL) begin
            prodx_reg <= px_full[CW-1:0];
            prody_reg <= py_full[CW-1:0];
        end
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job.col   = col_reg;
    assign job.row   = row_reg;
    assign job.cx    = cfg.left_x + prodx_reg;
    assign job.cy    = cfg.top_y + prody_reg;

endmodule

// ===== rtl/core/mpe_fifo.sv =====
// Short request queue that decouples the front end from the iteration engine.
module mpe_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  mpe_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mpe_pkg::job_t pop_data
);

    localparam int DEPTH = mpe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpe_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/mpe_iter.sv =====
// Back end: escape-time iteration on one shared multiplier, with an output register.
module mpe_iter #(
    parameter int FRAC_BITS = 18
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [mpe_pkg::ITER_W-1:0] max_iterations,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  mpe_pkg::job_t              job,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mpe_pkg::POS_W-1:0]  out_col,
    output logic [mpe_pkg::POS_W-1:0]  out_row,
    output logic [mpe_pkg::ITER_W-1:0] out_count
);

    localparam int CW = mpe_pkg::COORD_W;
    localparam int YW = 2 * CW;
    localparam int IW = mpe_pkg::ITER_W;
    localparam int PW = mpe_pkg::POS_W;
    localparam logic [CW-1:0] FOUR = 32'd4 << FRAC_BITS;

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_CHECK = 7'b0000010,
        B_XYH   = 7'b0000100,
        B_YUPD  = 7'b0001000,
        B_YYL   = 7'b0010000,
        B_YYH   = 7'b0100000,
        B_Y2    = 7'b1000000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [CW-1:0] x_reg, xn_reg, x2_reg, y2_reg, cx_reg, cy_reg;
    logic [YW-1:0] y_reg, acc_reg, prod_reg;
    logic [IW-1:0] iter_reg;
    logic [PW-1:0] col_reg, row_reg;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_col_reg, out_row_reg;
    logic [IW-1:0] out_count_reg;

    logic [CW-1:0]   mul_a, mul_b;
    logic            mul_sgn;
    logic [YW+1:0]   mul_full;
    logic [CW-1:0]   sum_sq;
    logic            finish;
    logic            out_free;
    logic            take_job;
    logic            emit;
    logic [CW-1:0]   xy_hi;
    logic [YW-1:0]   pxy, pxy_sh, y_next;
    logic [YW-1:0]   pyy;

    // Loop test on the registered squares
    assign sum_sq   = x2_reg + y2_reg;
    assign finish   = ($signed(sum_sq) > $signed(FOUR)) || (iter_reg >= max_iterations);
    assign out_free = !out_valid_reg || out_ready;
    assign take_job = (state_reg == B_IDLE) && job_valid;
    assign emit     = (state_reg == B_CHECK) && finish && out_free;

    // Operand selection for the shared 32 by 32 multiplier
    always_comb begin
        mul_a   = x_reg;
        mul_b   = y_reg[CW-1:0];
        mul_sgn = 1'b0;
        case (state_reg)
            B_XYH: begin
                mul_b = y_reg[YW-1:CW];
            end
            B_YUPD: begin
                mul_a   = xn_reg;
                mul_b   = xn_reg;
                mul_sgn = 1'b1;
            end
            B_YYL: begin
                mul_a = y_reg[CW-1:0];
            end
            B_YYH: begin
                mul_a = y_reg[CW-1:0];
                mul_b = y_reg[YW-1:CW];
            end
            default: begin
                mul_a = x_reg;
            end
        endcase
    end

    assign mul_full = $signed({mul_sgn & mul_a[CW-1], mul_a})
                    * $signed({mul_sgn & mul_b[CW-1], mul_b});

    // x*y modulo 2^64 from the partial products, then the new y
    assign xy_hi  = prod_reg[CW-1:0] - (x_reg[CW-1] ? y_reg[CW-1:0] : '0);
    assign pxy    = acc_reg + {xy_hi, {CW{1'b0}}};
    assign pxy_sh = $signed(pxy) >>> FRAC_BITS;
    assign y_next = {pxy_sh[YW-2:0], 1'b0} + {{CW{cy_reg[CW-1]}}, cy_reg};

    // y*y modulo 2^64: low product plus twice the cross term
    assign pyy = acc_reg + {prod_reg[CW-2:0], 1'b0, {CW{1'b0}}};

    // Walk the iteration phases
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (job_valid) state_next = B_CHECK;
            end
            B_CHECK: begin
                if (!finish) begin
                    state_next = B_XYH;
                end else if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            B_XYH:   state_next = B_YUPD;
            B_YUPD:  state_next = B_YYL;
            B_YYL:   state_next = B_YYH;
            B_YYH:   state_next = B_Y2;
            B_Y2:    state_next = B_CHECK;
            default: state_next = B_IDLE;
        endcase
    end

    // Hold a result until taken, load a new one when the engine finishes
    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        if (emit) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        prod_reg <= mul_full[YW-1:0];
        if (take_job) begin
            col_reg  <= job.col;
            row_reg  <= job.row;
            cx_reg   <= job.cx;
            cy_reg   <= job.cy;
            x_reg    <= '0;
            y_reg    <= '0;
            x2_reg   <= '0;
            y2_reg   <= '0;
            iter_reg <= '0;
        end
        if ((state_reg == B_CHECK) && !finish) begin
            xn_reg <= x2_reg - y2_reg + cx_reg;
        end
        if ((state_reg == B_XYH) || (state_reg == B_YYH)) begin
            acc_reg <= prod_reg;
        end
        if (state_reg == B_YUPD) begin
            y_reg <= y_next;
            x_reg <= xn_reg;
        end
        if (state_reg == B_YYL) begin
            x2_reg <= prod_reg[FRAC_BITS+CW-1:FRAC_BITS];
        end
        if (state_reg == B_Y2) begin
            y2_reg   <= pyy[FRAC_BITS+CW-1:FRAC_BITS];
            iter_reg <= iter_reg + 1'b1;
        end
        if (emit) begin
            out_col_reg   <= col_reg;
            out_row_reg   <= row_reg;
            out_count_reg <= iter_reg;
        end
    end

    assign job_ready = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_count = out_count_reg;

endmodule

// ===== rtl/core/mandelbrot_pixel_escape_time_core.sv =====
// Top level of the Mandelbrot escape-time core: config registers, front, queue, back.
//
//   channel   direction  handshake              payload
//   s_        in         s_tvalid / s_tready    s_tdata: pixel_col, pixel_row
//   m_        out        m_tvalid / m_tready    m_tdata: out_col, out_row, escape_count
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Front end: works on one pixel at a time, with the bit-serial divider forming the
// horizontal and then the vertical step.
// Back end: works on one pixel at a time, iterating on the one shared 32 by 32 multiplier
// (five products per iteration). Sustained throughput is that of the slower end.
// Reset (aresetn low, synchronous) empties the queue and restores the register defaults.
// A result waiting in the output register stalls the back end only when it finishes the
// next pixel; the two-entry queue lets the front end run ahead meanwhile.
module mandelbrot_pixel_escape_time_core #(
    parameter int FRAC_BITS       = 18,
    parameter int STEP_SCALE_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mpe_pkg::S_TDATA_W-1:0]   s_tdata,   // pixel_col, pixel_row, pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mpe_pkg::M_TDATA_W-1:0]   m_tdata,   // out_col, out_row, escape_count, pad
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW = mpe_pkg::POS_W;
    localparam int IW = mpe_pkg::ITER_W;
    localparam int DW = mpe_pkg::DIM_W;

    mpe_pkg::cfg_t cfg_reg;
    mpe_pkg::job_t front_job, back_job;

    logic          front_valid, front_ready;
    logic          back_valid, back_ready;
    logic [PW-1:0] res_col, res_row;
    logic [IW-1:0] res_count;

    // Configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_x         <= 32'hFFFD_0000;
            cfg_reg.top_y          <= 32'hFFFD_0000;
            cfg_reg.right_x        <= 32'h0003_0000;
            cfg_reg.bottom_y       <= 32'h0003_0000;
            cfg_reg.image_width    <= 11'd96;
            cfg_reg.image_height   <= 11'd64;
            cfg_reg.max_iterations <= 16'd255;
        end else if (cfg_valid) begin
            case (cfg_index)
                mpe_pkg::CFG_LEFT_X:   cfg_reg.left_x         <= cfg_data;
                mpe_pkg::CFG_TOP_Y:    cfg_reg.top_y          <= cfg_data;
                mpe_pkg::CFG_RIGHT_X:  cfg_reg.right_x        <= cfg_data;
                mpe_pkg::CFG_BOTTOM_Y: cfg_reg.bottom_y       <= cfg_data;
                mpe_pkg::CFG_WIDTH:    cfg_reg.image_width    <= cfg_data[DW-1:0];
                mpe_pkg::CFG_HEIGHT:   cfg_reg.image_height   <= cfg_data[DW-1:0];
                mpe_pkg::CFG_MAX_ITER: cfg_reg.max_iterations <= cfg_data[IW-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mpe_front #(
        .STEP_SCALE_BITS (STEP_SCALE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_col    (s_tdata[PW-1:0]),
        .in_row    (s_tdata[2*PW-1:PW]),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    mpe_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    mpe_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_iterations (cfg_reg.max_iterations),
        .job_valid      (back_valid),
        .job_ready      (back_ready),
        .job            (back_job),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_col        (res_col),
        .out_row        (res_row),
        .out_count      (res_count)
    );

    // Pack the result, first field lowest
    assign m_tdata = {{(mpe_pkg::M_TDATA_W - 2*PW - IW){1'b0}}, res_count, res_row, res_col};

endmodule

// ===== tb/sv/tb_mandelbrot_pixel_escape_time_core.sv =====
// Self-checking testbench for the Mandelbrot escape-time core: stream driver, monitor, predictor.
module tb_mandelbrot_pixel_escape_time_core;

    localparam int FRAC_BITS       = 18;
    localparam int STEP_SCALE_BITS = 12;
    localparam int FOUR_FIXED      = 4 << FRAC_BITS;
    localparam int RANDOM_PHASES   = 10;
    localparam int PIXELS_PER_PHASE = 130;

    localparam int ITER_W     = mpe_pkg::ITER_W;
    localparam int POS_W      = mpe_pkg::POS_W;
    localparam int DIM_W      = mpe_pkg::DIM_W;
    localparam int S_TDATA_W  = mpe_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = mpe_pkg::M_TDATA_W;
    localparam int CFG_IDX_W  = mpe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mpe_pkg::CFG_DATA_W;

    // Result fields from the lowest bit up: column, row, escape count
    typedef struct packed {
        logic [ITER_W-1:0] count;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } escape_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // pixel_col, pixel_row, pad
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // out_col, out_row, escape_count, pad
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Window settings as the block should hold them
    mpe_pkg::cfg_t          win;

    logic [S_TDATA_W-1:0]   pending_pixels[$];
    escape_t                awaited_results[$];
    escape_t                seen;
    escape_t                want;

    int unsigned            send_idle_pct = 0;
    int unsigned            recv_idle_pct = 0;
    int unsigned            mismatches = 0;
    int unsigned            pixels_sent = 0;
    int unsigned            results_checked = 0;
    int unsigned            settings_used = 0;

    mandelbrot_pixel_escape_time_core #(
        .FRAC_BITS       (FRAC_BITS),
        .STEP_SCALE_BITS (STEP_SCALE_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Pixel step along one axis: scaled span over the pixel count, truncated, scaled back
    function automatic longint plane_step(logic [31:0] a, logic [31:0] b, logic [10:0] n);
        longint span;
        longint quot;
        if (n == '0) begin
            return 0;
        end
        span = longint'($signed(b)) - longint'($signed(a));
        quot = (span <<< STEP_SCALE_BITS) / longint'({53'd0, n});
        return quot >>> STEP_SCALE_BITS;
    endfunction

    // Escape-time iteration with the block's truncations and wrap-around
    function automatic logic [ITER_W-1:0] mandel_iterations(logic [31:0] cx, logic [31:0] cy,
                                                           logic [ITER_W-1:0] limit);
        longint      zx;
        longint      zy;
        longint      prod;
        logic [31:0] x2;
        logic [31:0] y2;
        logic [31:0] xn;
        logic [31:0] mag;
        int unsigned n;
        zx = 0;
        zy = 0;
        x2 = '0;
        y2 = '0;
        n = 0;
        mag = '0;
        while ($signed(mag) <= FOUR_FIXED && n < limit) begin
            xn = x2 - y2 + cx;
            prod = zx * zy;
            zy = 2 * (prod >>> FRAC_BITS) + longint'($signed(cy));
            zx = longint'($signed(xn));
            prod = (zx * zx) >>> FRAC_BITS;
            x2 = prod[31:0];
            prod = (zy * zy) >>> FRAC_BITS;
            y2 = prod[31:0];
            mag = x2 + y2;
            n++;
        end
        return n[ITER_W-1:0];
    endfunction

    // Map a pixel request into the plane and work out its escape count
    function automatic escape_t predict_escape(logic [S_TDATA_W-1:0] word);
        escape_t r;
        longint  dx;
        longint  dy;
        longint  pos;
        logic [31:0] cx;
        logic [31:0] cy;
        r.col = word[POS_W-1:0];
        r.row = word[2*POS_W-1:POS_W];
        dx = plane_step(win.left_x, win.right_x, win.image_width);
        dy = plane_step(win.top_y, win.bottom_y, win.image_height);
        pos = longint'($signed(win.left_x)) + dx * longint'({54'd0, r.col});
        cx = pos[31:0];
        pos = longint'($signed(win.top_y)) + dy * longint'({54'd0, r.row});
        cy = pos[31:0];
        r.count = mandel_iterations(cx, cy, win.max_iterations);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input escape_t exp_v, input escape_t got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected col %0d row %0d count %0d, got col %0d row %0d count %0d",
                     $realtime, what, exp_v.col, exp_v.row, exp_v.count,
                     got_v.col, got_v.row, got_v.count);
        end
    endtask

    // Request driver: present the next pending pixel once the slot is free
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                awaited_results.push_back(predict_escape(s_tdata));
                pixels_sent++;
            end
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pixels.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = escape_t'(m_tdata[$bits(escape_t)-1:0]);
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with none awaited", '0, seen);
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (seen.col != want.col || seen.row != want.row || seen.count != want.count) begin
                    flag_mismatch("result mismatch", want, seen);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Write one register and mirror it in the predictor; returns at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            mpe_pkg::CFG_LEFT_X:   win.left_x = value;
            mpe_pkg::CFG_TOP_Y:    win.top_y = value;
            mpe_pkg::CFG_RIGHT_X:  win.right_x = value;
            mpe_pkg::CFG_BOTTOM_Y: win.bottom_y = value;
            mpe_pkg::CFG_WIDTH:    win.image_width = value[DIM_W-1:0];
            mpe_pkg::CFG_HEIGHT:   win.image_height = value[DIM_W-1:0];
            mpe_pkg::CFG_MAX_ITER: win.max_iterations = value[ITER_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, then load a whole window while the core is idle
    task automatic set_window(input logic [31:0] l, input logic [31:0] t, input logic [31:0] r,
                              input logic [31:0] b, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h, input logic [ITER_W-1:0] mx);
        wait_idle();
        @(posedge aclk);
        write_reg(mpe_pkg::CFG_LEFT_X, l);
        write_reg(mpe_pkg::CFG_TOP_Y, t);
        write_reg(mpe_pkg::CFG_RIGHT_X, r);
        write_reg(mpe_pkg::CFG_BOTTOM_Y, b);
        write_reg(mpe_pkg::CFG_WIDTH, {21'd0, w});
        write_reg(mpe_pkg::CFG_HEIGHT, {21'd0, h});
        write_reg(mpe_pkg::CFG_MAX_ITER, {16'd0, mx});
        cfg_valid <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    function automatic void queue_pixel(int unsigned col, int unsigned row);
        pending_pixels.push_back({4'd0, row[POS_W-1:0], col[POS_W-1:0]});
    endfunction

    // Mostly inside the image, sometimes anywhere in the 10-bit range
    function automatic int unsigned pick_index(logic [DIM_W-1:0] n);
        if (n != '0 && n <= 1024 && $urandom_range(3) != 0) begin
            return $urandom_range(0, n - 1);
        end
        return $urandom_range(0, 1023);
    endfunction

    function automatic logic [31:0] pick_corner();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(5))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd1024;
            3: return 11'd2047;
            default: return 11'($urandom_range(1, 1024));
        endcase
    endfunction

    initial begin
        logic [31:0]       l;
        logic [31:0]       t;
        logic [31:0]       r;
        logic [31:0]       b;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [ITER_W-1:0] mx;
        win.left_x = -196608;
        win.top_y = -196608;
        win.right_x = 196608;
        win.bottom_y = 196608;
        win.image_width = 11'd96;
        win.image_height = 11'd64;
        win.max_iterations = 16'd255;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default window: corners, edges, beyond the image and points inside the set
        send_idle_pct = 13;
        recv_idle_pct = 83;
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(682, 341);
        queue_pixel(341, 682);
        queue_pixel(48, 32);
        queue_pixel(95, 63);
        queue_pixel(96, 64);
        queue_pixel(30, 32);
        queue_pixel(40, 20);

        // Zero pixel counts: every pixel lands on the corner
        set_window(-131072, 78643, 262144, 262144, 11'd0, 11'd0, 16'd40);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(512, 7);

        // Largest pixel counts the registers hold
        set_window(-655360, -327680, 262144, 327680, 11'd2047, 11'd2047, 16'd40);
        queue_pixel(1023, 1023);
        queue_pixel(0, 0);
        queue_pixel(700, 300);

        // Point far past the 32-bit range wraps round
        set_window(32'h7FF0_0000, 32'h7FF0_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   11'd1, 11'd1, 16'd20);
        queue_pixel(1023, 1023);
        queue_pixel(1, 1);
        queue_pixel(600, 5);

        // No iterations allowed
        set_window(-196608, -196608, 196608, 196608, 11'd96, 11'd64, 16'd0);
        queue_pixel(48, 32);
        queue_pixel(0, 0);

        // Random windows under each back-pressure mix
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    l = -655360;
                    t = -327680;
                    r = 262144;
                    b = 327680;
                    w = 11'($urandom_range(16, 128));
                    h = 11'($urandom_range(16, 96));
                    mx = 16'($urandom_range(16, 64));
                end
                1: begin
                    l = -524288 + $urandom_range(0, 655360);
                    t = -327680 + $urandom_range(0, 655360);
                    r = l + $urandom_range(1000, 131072);
                    b = t + $urandom_range(1000, 131072);
                    w = ($urandom_range(3) == 0) ? 11'd1024 : 11'($urandom_range(1, 1024));
                    h = ($urandom_range(3) == 0) ? 11'd1024 : 11'($urandom_range(1, 1024));
                    mx = 16'd64;
                end
                2: begin
                    l = pick_corner();
                    t = pick_corner();
                    r = pick_corner();
                    b = pick_corner();
                    w = pick_dim();
                    h = pick_dim();
                    mx = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
                end
                default: begin
                    // Every point starts beyond radius two, so the top limit costs nothing
                    l = 786432 + $urandom_range(0, 262144);
                    r = l + $urandom_range(0, 262144);
                    t = -262144 + $urandom_range(0, 524288);
                    b = t;
                    w = 11'($urandom_range(256, 1024));
                    h = 11'($urandom_range(1, 2047));
                    mx = 16'hFFFF;
                end
            endcase
            set_window(l, t, r, b, w, h, mx);
            if (ph < 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 83;
            end else if (ph < 6) begin
                send_idle_pct = 83;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
                queue_pixel(pick_index(win.image_width), pick_index(win.image_height));
            end
        end

        // Drain and allow for any stray late result
        wait_idle();
        repeat (200) @(negedge aclk);
        mismatches += awaited_results.size();
        $display("Covered %0d pixels over %0d register settings plus the reset window;",
                 pixels_sent, settings_used);
        $display("%0d escape counts compared, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #16_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
